>>> rtl/sbli_pkg.sv
// Shared types and codes for the sorted breakpoint interpolation table.
`timescale 1ns / 1ps
package sbli_pkg;

	localparam int unsigned DEF_TABLE_DEPTH = 64;
	localparam int unsigned ANG_W = 16;
	localparam int unsigned LIFT_W = 16;
	localparam int unsigned NUM_W = 32;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_QUERY = 2'd1,
		FN_CLEAR = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Selection a cell reports when it holds the first angle at or above the query
	typedef struct packed {
		logic                      hit;
		logic signed [ANG_W-1:0]   ang;
		logic signed [LIFT_W-1:0]  lft;
		logic signed [ANG_W-1:0]   prev_ang;
		logic signed [LIFT_W-1:0]  prev_lft;
	} sel_t;

endpackage

>>> rtl/sbli_cell.sv
// One breakpoint cell of the sorted insertion chain.
`timescale 1ns / 1ps
module sbli_cell (
	input  logic                clk,
	input  logic                vld,
	input  logic                ins_en,
	input  logic signed [15:0]  new_ang,
	input  logic signed [15:0]  new_lft,
	input  logic signed [15:0]  prev_ang,
	input  logic signed [15:0]  prev_lft,
	input  logic                prev_gt,
	input  logic                prev_ge,
	input  logic signed [15:0]  qry_ang,
	output logic signed [15:0]  ang,
	output logic signed [15:0]  lft,
	output logic                gt,
	output logic                ge,
	output sbli_pkg::sel_t      sel
);
	import sbli_pkg::*;

	logic signed [15:0] ang_q;
	logic signed [15:0] lft_q;

	// Flag slots that must move right on insert
	assign gt = !vld || (ang_q > new_ang);
	assign ge = vld && (ang_q >= qry_ang);

	// Shift right from the neighbor or take the new point
	always_ff @(posedge clk) begin
		if (ins_en && gt) begin
			if (prev_gt) begin
				ang_q <= prev_ang;
				lft_q <= prev_lft;
			end else begin
				ang_q <= new_ang;
				lft_q <= new_lft;
			end
		end
	end

	assign ang = ang_q;
	assign lft = lft_q;

	// Report this cell and its left neighbor when it is the bracket's upper end
	always_comb begin
		sel = '0;
		if (ge && !prev_ge) begin
			sel.hit      = 1'b1;
			sel.ang      = ang_q;
			sel.lft      = lft_q;
			sel.prev_ang = prev_ang;
			sel.prev_lft = prev_lft;
		end
	end

endmodule

>>> rtl/sbli_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
module sbli_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sbli_pkg::NUM_W-1:0]       num,
	input  logic [15:0]                      den,
	output logic                             done,
	output logic [sbli_pkg::NUM_W-1:0]       quo
);
	import sbli_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [15:0]       den_q;
	logic              done_q;
	logic [16:0]       trial;
	logic              fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Count down the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit and subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/sorted_breakpoint_linear_interp.sv
// Top level: sorted breakpoint table with linear interpolation between neighbors.
//
// channel | dir | tdata (low bit up)              | tuser
// s_      | in  | angle[15:0], lift[31:16]        | func[1:0]
// m_      | out | lift_out[15:0], points_held     | status[1:0]
//
// Load, clear and unused codes finish in the accept cycle; one result follows.
// An interpolating query runs select, multiply, divider load, a divider step per
// quotient bit, divider done and finish, in that order, before its result is given.
// The divider's one bit per cycle iteration sets the query time.
// Reset empties the table; the cell storage itself is not cleared.
// One item is in flight; a new one is taken once the result slot is free.
`timescale 1ns / 1ps
module sorted_breakpoint_linear_interp #(
	parameter int unsigned TABLE_DEPTH = sbli_pkg::DEF_TABLE_DEPTH,
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int unsigned OUT_W = ((16 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // angle[15:0], lift[31:16]
	input  logic [1:0]       s_tuser,   // func[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // lift_out[15:0], points_held, zero fill
	output logic [1:0]       m_tuser    // status[1:0]
);
	import sbli_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_QRY  = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [15:0] qry_q;
	logic signed [15:0] in_ang;
	logic signed [15:0] in_lft;
	func_t              in_func;
	logic               accept;
	logic               ins_en;
	logic               full;
	logic               qry_end;
	logic               res_set;

	logic [TABLE_DEPTH-1:0]  vld;
	logic [TABLE_DEPTH:0]    gt_c;
	logic [TABLE_DEPTH:0]    ge_c;
	logic signed [15:0]      ang_c [TABLE_DEPTH+1];
	logic signed [15:0]      lft_c [TABLE_DEPTH+1];
	sel_t                    sel_v [TABLE_DEPTH];
	sel_t                    sel;

	logic signed [15:0] a_q, c_q, la_q, lc_q;
	logic signed [33:0] prod_s2;
	logic [15:0]        den_s2;
	logic signed [15:0] la_s2;
	logic               div_go_q;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [NUM_W-1:0]   mag;
	logic signed [16:0] dq, dl;
	logic signed [16:0] span;
	logic signed [NUM_W:0] sq;
	logic signed [NUM_W:0] res_full;

	logic               out_vld_q;
	logic signed [15:0] out_lift_q;
	status_t            out_st_q;

	assign in_ang  = s_tdata[15:0];
	assign in_lft  = s_tdata[31:16];
	assign in_func = func_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE) && (!out_vld_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(TABLE_DEPTH);
	assign ins_en   = accept && (in_func == FN_LOAD) && !full;

	// Cell chain, left neighbor feeds each cell
	assign gt_c[0]  = 1'b0;
	assign ge_c[0]  = 1'b0;
	assign ang_c[0] = '0;
	assign lft_c[0] = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		assign vld[g] = count_q > CNT_W'(g);
		sbli_cell u_cell (
			.clk      (clk),
			.vld      (vld[g]),
			.ins_en   (ins_en),
			.new_ang  (in_ang),
			.new_lft  (in_lft),
			.prev_ang (ang_c[g]),
			.prev_lft (lft_c[g]),
			.prev_gt  (gt_c[g]),
			.prev_ge  (ge_c[g]),
			.qry_ang  (qry_q),
			.ang      (ang_c[g+1]),
			.lft      (lft_c[g+1]),
			.gt       (gt_c[g+1]),
			.ge       (ge_c[g+1]),
			.sel      (sel_v[g])
		);
	end

	// Merge the single reporting cell
	always_comb begin
		sel = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sel = sel | sel_v[i];
		end
	end

	// Query ends at selection when empty, out of range or an exact match
	assign qry_end = (count_q == '0) || !sel.hit || (qry_q < ang_c[1])
			|| (sel.ang == qry_q);
	assign res_set = (accept && (in_func != FN_QUERY)) || ((state_q == S_QRY) && qry_end)
			|| (state_q == S_FIN);

	// Operand differences for the multiply stage
	assign dq   = 17'(qry_q) - 17'(a_q);
	assign dl   = 17'(lc_q) - 17'(la_q);
	assign span = 17'(c_q) - 17'(a_q);
	assign mag  = prod_s2[33] ? NUM_W'(-prod_s2) : NUM_W'(prod_s2);
	assign sq   = prod_s2[33] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign res_full = sq + (NUM_W+1)'(la_s2);
	// Start the divider once the product register holds this query's product
	assign div_start = div_go_q;

	sbli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag),
		.den    (den_s2),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequence control, count and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_vld_q <= 1'b0;
			div_go_q  <= 1'b0;
		end else begin
			div_go_q <= (state_q == S_MUL);
			if (res_set) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_func)
							FN_LOAD: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							FN_QUERY: state_q <= S_QRY;
							FN_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_QRY: begin
					if (qry_end) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					qry_q      <= in_ang;
					out_lift_q <= '0;
					out_st_q   <= ((in_func == FN_LOAD) && full) ? ST_FULL : ST_OK;
				end
			end
			S_QRY: begin
				a_q  <= sel.prev_ang;
				c_q  <= sel.ang;
				la_q <= sel.prev_lft;
				lc_q <= sel.lft;
				priority if (count_q == '0) begin
					out_st_q <= ST_EMPTY;
				end else if (!sel.hit || (qry_q < ang_c[1])) begin
					out_st_q <= ST_RANGE;
				end else if (sel.ang == qry_q) begin
					out_lift_q <= sel.lft;
					out_st_q   <= ST_OK;
				end else begin
					out_st_q <= ST_OK;
				end
			end
			S_MUL: begin
				prod_s2 <= dq * dl;
				den_s2  <= span[15:0];
				la_s2   <= la_q;
			end
			S_DIV: ;
			S_FIN: out_lift_q <= res_full[15:0];
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = OUT_W'({count_q, out_lift_q});

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count above table depth");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE))
		else $error("ready outside idle");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_func == FN_LOAD) && full) |=> (m_tuser == ST_FULL) && $stable(count_q))
		else $error("full load changed table");
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> m_tvalid && (state_q == S_IDLE))
		else $error("query finish lost result");
`endif

endmodule

>>> tb/tb_sorted_breakpoint_linear_interp.sv
// Testbench for the sorted breakpoint table with linear interpolation.
`timescale 1ns / 1ps
module tb_sorted_breakpoint_linear_interp;
	import sbli_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned OUT_W = 24;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [15:0] lift_out;
		status_t            status;
		logic [6:0]         points_held;
	} answer_t;

	typedef struct {
		func_t              func;
		logic signed [15:0] angle;
		logic signed [15:0] lift;
		bit                 typed;
		logic signed [15:0] want_lift;
		status_t            want_status;
		logic [6:0]         want_points;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;

	// Predictor state
	logic signed [15:0] bp_angle [DEPTH];
	logic signed [15:0] bp_lift [DEPTH];
	int unsigned        bp_count = 0;

	answer_t     pending_answers[$];
	int unsigned mismatches = 0;
	int unsigned n_loads = 0, n_queries = 0, n_full = 0, n_range = 0, n_interp = 0;
	int unsigned n_results = 0;
	int unsigned idle_cycles = 0;
	bit          hold_sink = 1'b0;
	bit          no_gaps = 1'b0;

	sorted_breakpoint_linear_interp i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	// Update the breakpoint table and compute the answer for one transaction
	function automatic answer_t predict_table_step(func_t fn, logic signed [15:0] ang,
			logic signed [15:0] lft);
		answer_t     r;
		int unsigned pos, i;
		longint      a, c, la, lc, num;
		r.lift_out = '0;
		r.status = ST_OK;
		case (fn)
			FN_LOAD: begin
				n_loads++;
				if (bp_count >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					pos = bp_count;
					while (pos > 0 && bp_angle[pos-1] > ang) pos--;
					for (i = bp_count; i > pos; i--) begin
						bp_angle[i] = bp_angle[i-1];
						bp_lift[i] = bp_lift[i-1];
					end
					bp_angle[pos] = ang;
					bp_lift[pos] = lft;
					bp_count++;
				end
			end
			FN_QUERY: begin
				n_queries++;
				if (bp_count == 0) begin
					r.status = ST_EMPTY;
				end else if (ang < bp_angle[0] || ang > bp_angle[bp_count-1]) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					i = 0;
					while (i + 1 < bp_count && bp_angle[i] < ang) i++;
					if (bp_angle[i] == ang) begin
						r.lift_out = bp_lift[i];
					end else begin
						a = bp_angle[i-1];
						c = bp_angle[i];
						la = bp_lift[i-1];
						lc = bp_lift[i];
						num = (longint'(ang) - a) * (lc - la);
						r.lift_out = 16'(la + num / (c - a));
						n_interp++;
					end
				end
			end
			FN_CLEAR: bp_count = 0;
			default: ;
		endcase
		r.points_held = 7'(bp_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int unsigned gap_cycles();
		int unsigned p;
		if (no_gaps) return 0;
		p = $urandom_range(0, 19);
		if (p < 12) return 0;
		if (p < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one transaction and predict at the accepting edge
	task automatic send_item(func_t fn, logic signed [15:0] ang, logic signed [15:0] lft,
			bit typed = 1'b0,
			answer_t typed_ans = '{lift_out: '0, status: ST_OK, points_held: '0});
		answer_t     ans;
		int unsigned g;
		g = gap_cycles();
		repeat (g) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {lft, ang};
		s_tuser = fn;
		do @(posedge clk); while (!s_tready);
		ans = predict_table_step(fn, ang, lft);
		pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tuser = 2'($urandom_range(0, 3));
		s_tdata = $urandom;
	endtask

	// Receiver readiness with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_sink) m_tready = 1'b0;
		else if (no_gaps) m_tready = 1'b1;
		else m_tready = ($urandom_range(0, 19) < 14) || ($urandom_range(0, 3) == 0);
	end

	// Check results and watch for a hang
	always @(posedge clk) begin
		answer_t w;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("MISMATCH unexpected result at %0t", $realtime);
			end else begin
				w = pending_answers.pop_front();
				if ($signed(m_tdata[15:0]) != w.lift_out)
					report_mismatch("lift_out", $signed(m_tdata[15:0]), w.lift_out);
				if (m_tuser != w.status) report_mismatch("status", m_tuser, w.status);
				if (m_tdata[22:16] != w.points_held)
					report_mismatch("points_held", m_tdata[22:16], w.points_held);
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_breakpoint_linear_interp test failed");
			$finish;
		end
	end

	// Long receiver stall, counted in cycles
	task automatic stall_receiver(int unsigned cycles);
		hold_sink = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_sink = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_answers.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 15) - 8);
			2: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
			default: return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_query();
		int lo, hi;
		if (bp_count == 0 || $urandom_range(0, 9) < 2) return pick_angle();
		lo = bp_angle[0];
		hi = bp_angle[bp_count-1];
		if ($urandom_range(0, 4) == 0) return bp_angle[$urandom_range(0, bp_count - 1)];
		return 16'($signed(lo + int'($urandom_range(0, hi - lo))));
	endfunction

	stim_row_t directed_rows[$] = '{
		'{FN_QUERY, 16'sd0, 16'sd0, 1, 16'sd0, ST_EMPTY, 7'd0},
		'{FN_NOP, 16'sd5, 16'sd9, 1, 16'sd0, ST_OK, 7'd0},
		'{FN_LOAD, -16'sh8000, 16'sh7fff, 1, 16'sd0, ST_OK, 7'd1},
		'{FN_QUERY, 16'sd0, 16'sd0, 1, 16'sd0, ST_RANGE, 7'd1},
		'{FN_LOAD, 16'sh7fff, -16'sh8000, 1, 16'sd0, ST_OK, 7'd2},
		'{FN_QUERY, -16'sh8000, 16'sd0, 1, 16'sh7fff, ST_OK, 7'd2},
		'{FN_QUERY, 16'sh7fff, 16'sd0, 1, -16'sh8000, ST_OK, 7'd2},
		'{FN_QUERY, 16'sd0, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, -16'sd1, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, 16'sh7ffe, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_LOAD, 16'sh7fff, 16'sd5, 1, 16'sd0, ST_OK, 7'd3},
		'{FN_QUERY, 16'sh7fff, 16'sd0, 1, -16'sh8000, ST_OK, 7'd3},
		'{FN_LOAD, 16'sd0, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, 16'sd1, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_CLEAR, 16'sd0, 16'sd0, 1, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, 16'sd0, 16'sd0, 1, 16'sd0, ST_EMPTY, 7'd0},
		'{FN_LOAD, 16'sd100, 16'sd10, 1, 16'sd0, ST_OK, 7'd1},
		'{FN_QUERY, 16'sd99, 16'sd0, 1, 16'sd0, ST_RANGE, 7'd1},
		'{FN_QUERY, 16'sd101, 16'sd0, 1, 16'sd0, ST_RANGE, 7'd1},
		'{FN_QUERY, 16'sd100, 16'sd0, 1, 16'sd10, ST_OK, 7'd1},
		'{FN_LOAD, 16'sd103, -16'sd10, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, 16'sd101, 16'sd0, 0, 16'sd0, ST_OK, 7'd0},
		'{FN_QUERY, 16'sd102, 16'sd0, 0, 16'sd0, ST_OK, 7'd0}
	};

	initial begin
		answer_t     t;
		func_t       fn;
		int unsigned k, p, clear_odds;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table
		foreach (directed_rows[r]) begin
			t.lift_out = directed_rows[r].want_lift;
			t.status = directed_rows[r].want_status;
			t.points_held = directed_rows[r].want_points;
			send_item(directed_rows[r].func, directed_rows[r].angle, directed_rows[r].lift,
				directed_rows[r].typed, t);
		end
		// Fill the table, then refuse one more
		while (bp_count < DEPTH) send_item(FN_LOAD, pick_angle(), 16'($urandom));
		t = '{lift_out: 16'sd0, status: ST_FULL, points_held: 7'd64};
		send_item(FN_LOAD, 16'sd0, 16'sd1, 1'b1, t);

		// Random part: segments with different clear rates so the table often fills
		clear_odds = 30;
		for (k = 0; k < 1900; k++) begin
			if (k % 200 == 0) begin
				clear_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 60);
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			if (k == 600) fork stall_receiver(400); join_none
			if (k == 1000) drain_results();
			p = $urandom_range(0, 999);
			if (clear_odds != 0 && p < clear_odds) fn = FN_CLEAR;
			else if (p > 980) fn = FN_NOP;
			else if (p % 2 == 0) fn = FN_LOAD;
			else fn = FN_QUERY;
			send_item(fn, fn == FN_QUERY ? pick_query() : pick_angle(), 16'($urandom));
		end
		no_gaps = 1'b0;

		drain_results();
		repeat (60) @(posedge clk);
		$display("Covered %0d loads (%0d refused on full), %0d queries", n_loads, n_full,
			n_queries);
		$display("%0d interpolated, %0d out of range, %0d results checked", n_interp, n_range,
			n_results);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("sorted_breakpoint_linear_interp test passed");
		else
			$display("sorted_breakpoint_linear_interp test failed");
		$finish;
	end

endmodule

>>> sorted_breakpoint_linear_interp.f
rtl/sbli_pkg.sv
rtl/sbli_cell.sv
rtl/sbli_div.sv
rtl/sorted_breakpoint_linear_interp.sv
tb/tb_sorted_breakpoint_linear_interp.sv
